/* rtl/ptss_pkg.sv */
`default_nettype none
package ptss_pkg;

   localparam int IdWidth    = 16;
   localparam int PriWidth   = 8;
   localparam int SliceWidth = 8;
   localparam int UsedWidth  = 32;

   // Slice length that the block starts with after reset.
   localparam logic [SliceWidth-1:0] SliceLengthReset = 8'd3;

   typedef enum logic [1:0] {
      TASK_READY   = 2'd0,
      TASK_RUNNING = 2'd1,
      TASK_BLOCKED = 2'd2
   } task_state_type;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_YIELD     = 3'd1,
      OP_CREATE    = 3'd2,
      OP_TERMINATE = 3'd3,
      OP_BLOCK     = 3'd4,
      OP_UNBLOCK   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_NOEFFECT = 2'd2,
      STATUS_KERNEL  = 2'd3
   } status_type;

endpackage
`default_nettype wire

/* rtl/priority_time_slice_scheduler.sv */
`default_nettype none
// Priority time-slice task scheduler. Each request transaction carries one
// operation (tick, yield, create, terminate, block, unblock) and produces exactly one
// response transaction. A single sequencer walks the task table one entry per clock
// with one shared compare unit, and a create scans the table anew for each candidate
// id that clashes. The block takes no new request while an operation is in progress
// or while its response waits, so the next request can be taken in the cycle after
// the response transaction is accepted. The slice length register must be written
// over the csr channel only while the block is idle, a rule for the user that the
// block itself does not enforce.
module priority_time_slice_scheduler
   import ptss_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_slice_length,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_operation,
   input  wire logic [15:0] req_task_id,
   input  wire logic [7:0]  req_task_priority,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_new_id,
   output logic             rsp_switched,
   output logic [$clog2(MAX_TASKS)-1:0]   rsp_previous_index,
   output logic [$clog2(MAX_TASKS)-1:0]   rsp_current_index,
   output logic [15:0]      rsp_current_id,
   output logic [$clog2(MAX_TASKS+1)-1:0] rsp_task_count
);

   localparam int IW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);

   logic [7:0]    slice_ff;
   logic          busy;
   logic          done;
   logic          start;
   logic [1:0]    status;
   logic [15:0]   new_id;
   logic          switched;
   logic [IW-1:0] prev_idx;
   logic [IW-1:0] cur_idx;
   logic [15:0]   cur_id;
   logic [CW-1:0] count;
   logic          pend_ff;

   assign csr_ready = 1'b1;
   assign req_stall = busy || pend_ff;
   assign start     = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff <= SliceLengthReset;
         pend_ff  <= 1'b0;
      end else begin
         if (csr_valid) slice_ff <= csr_slice_length;
         // The response register holds until the consumer takes the transaction.
         if (done) pend_ff <= 1'b1;
         else if (!rsp_stall) pend_ff <= 1'b0;
      end
   end

   ptss_core #(.MAX_TASKS(MAX_TASKS), .IW(IW), .CW(CW)) u_core (
      .clock, .reset,
      .slice_length(slice_ff),
      .start, .op(req_operation), .tid(req_task_id), .pri(req_task_priority),
      .busy, .done, .status, .new_id, .switched,
      .previous_index(prev_idx), .current_index(cur_idx), .current_id(cur_id),
      .task_count(count)
   );

   assign rsp_valid          = pend_ff;
   assign rsp_status         = status;
   assign rsp_new_id         = new_id;
   assign rsp_switched       = switched;
   assign rsp_previous_index = prev_idx;
   assign rsp_current_index  = cur_idx;
   assign rsp_current_id     = cur_id;
   assign rsp_task_count     = count;

endmodule
`default_nettype wire

/* rtl/ptss_core.sv */
`default_nettype none
// Sequencer with one shared compare unit that walks the task table one entry per cycle.
module ptss_core
   import ptss_pkg::*;
#(
   parameter int MAX_TASKS = 16,
   parameter int IW = $clog2(MAX_TASKS),
   parameter int CW = $clog2(MAX_TASKS + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [SliceWidth-1:0] slice_length,
   input  wire logic                  start,
   input  wire logic [2:0]            op,
   input  wire logic [IdWidth-1:0]    tid,
   input  wire logic [PriWidth-1:0]   pri,
   output logic                       busy,
   output logic                       done,
   output logic [1:0]                 status,
   output logic [IdWidth-1:0]         new_id,
   output logic                       switched,
   output logic [IW-1:0]              previous_index,
   output logic [IW-1:0]              current_index,
   output logic [IdWidth-1:0]         current_id,
   output logic [CW-1:0]              task_count
);

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_FIND_DONE, S_TICK, S_PICK, S_PICK_DONE,
      S_ALLOC, S_SHIFT, S_READ_ID, S_DONE
   } fsm_type;

   logic [IdWidth-1:0]    id_mem    [MAX_TASKS];
   logic [1:0]            st_mem    [MAX_TASKS];
   logic [PriWidth-1:0]   pri_mem   [MAX_TASKS];
   logic [SliceWidth-1:0] slice_mem [MAX_TASKS];
   logic [UsedWidth-1:0]  used_mem  [MAX_TASKS];

   fsm_type              fsm_ff;
   logic [CW-1:0]        count_ff;
   logic [IW-1:0]        run_ff;
   logic [IdWidth-1:0]   free_ff;
   logic [2:0]           op_ff;
   logic [IdWidth-1:0]   tid_ff;
   logic [PriWidth-1:0]  pri_ff;
   logic [CW-1:0]        scan_ff;
   logic [IW-1:0]        pos_ff;
   logic                 found_ff;
   logic [IW-1:0]        best_ff;
   logic [PriWidth-1:0]  best_pri_ff;
   logic [IdWidth-1:0]   cand_ff;
   logic [1:0]           status_ff;
   logic [IdWidth-1:0]   new_id_ff;
   logic                 sw_ff;
   logic [IW-1:0]        prev_ff;
   logic [IdWidth-1:0]   cur_id_ff;

   logic [CW-1:0] pos_ext;
   logic [CW-1:0] pos_inc;
   logic [IW-1:0] pos_next;
   logic [CW-1:0] run_ext;
   logic [CW-1:0] run_inc;
   logic [IW-1:0] run_next;
   logic [IdWidth-1:0] cand_inc;

   assign pos_ext  = CW'(pos_ff);
   assign pos_inc  = pos_ext + CW'(1);
   assign pos_next = (pos_inc >= count_ff) ? IW'(0) : pos_inc[IW-1:0];
   assign run_ext  = CW'(run_ff);
   assign run_inc  = run_ext + CW'(1);
   assign run_next = (run_inc >= count_ff) ? IW'(0) : run_inc[IW-1:0];
   assign cand_inc = (cand_ff == '1) ? IdWidth'(1) : cand_ff + IdWidth'(1);

   assign busy           = (fsm_ff != S_IDLE);
   assign done           = (fsm_ff == S_DONE);
   assign status         = status_ff;
   assign new_id         = new_id_ff;
   assign switched       = sw_ff;
   assign previous_index = prev_ff;
   assign current_index  = run_ff;
   assign current_id     = cur_id_ff;
   assign task_count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= S_IDLE;
         count_ff      <= CW'(1);
         run_ff        <= '0;
         free_ff       <= IdWidth'(1);
         id_mem[0]     <= '0;
         st_mem[0]     <= TASK_RUNNING;
         pri_mem[0]    <= '0;
         slice_mem[0]  <= SliceLengthReset;
         used_mem[0]   <= '0;
      end else begin
         case (fsm_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff     <= op;
                  tid_ff    <= tid;
                  pri_ff    <= pri;
                  prev_ff   <= run_ff;
                  new_id_ff <= '0;
                  sw_ff     <= 1'b0;
                  scan_ff   <= '0;
                  pos_ff    <= '0;
                  found_ff  <= 1'b0;
                  cand_ff   <= free_ff;
                  case (op)
                     OP_TICK: begin
                        status_ff <= STATUS_OK;
                        fsm_ff    <= S_TICK;
                     end
                     OP_YIELD: begin
                        if (st_mem[run_ff] == TASK_RUNNING) st_mem[run_ff] <= TASK_READY;
                        slice_mem[run_ff] <= '0;
                        status_ff <= STATUS_OK;
                        fsm_ff <= S_TICK;
                     end
                     OP_CREATE: begin
                        if (count_ff >= CW'(MAX_TASKS)) begin
                           status_ff <= STATUS_FULL;
                           fsm_ff    <= S_READ_ID;
                        end else begin
                           status_ff <= STATUS_OK;
                           fsm_ff <= S_ALLOC;
                        end
                     end
                     OP_TERMINATE: begin
                        if (tid == '0) begin
                           status_ff <= STATUS_KERNEL;
                           fsm_ff    <= S_READ_ID;
                        end else begin
                           status_ff <= STATUS_OK;
                           fsm_ff <= S_FIND;
                        end
                     end
                     OP_BLOCK, OP_UNBLOCK: begin
                        status_ff <= STATUS_OK;
                        fsm_ff    <= S_FIND;
                     end
                     default: begin
                        status_ff <= STATUS_NOEFFECT;
                        fsm_ff    <= S_READ_ID;
                     end
                  endcase
               end
            end
            // Linear search for the first entry holding tid_ff.
            S_FIND: begin
               if (scan_ff >= count_ff) begin
                  status_ff <= STATUS_NOEFFECT;
                  fsm_ff    <= S_READ_ID;
               end else if (id_mem[scan_ff[IW-1:0]] == tid_ff) begin
                  pos_ff <= scan_ff[IW-1:0];
                  fsm_ff <= S_FIND_DONE;
               end else begin
                  scan_ff <= scan_ff + CW'(1);
               end
            end
            S_FIND_DONE: begin
               if (op_ff == OP_TERMINATE) begin
                  fsm_ff <= S_SHIFT;
               end else if (op_ff == OP_BLOCK) begin
                  if (st_mem[pos_ff] == TASK_RUNNING) st_mem[pos_ff] <= TASK_BLOCKED;
                  else status_ff <= STATUS_NOEFFECT;
                  fsm_ff <= S_READ_ID;
               end else begin
                  if (st_mem[pos_ff] == TASK_BLOCKED) st_mem[pos_ff] <= TASK_READY;
                  else status_ff <= STATUS_NOEFFECT;
                  fsm_ff <= S_READ_ID;
               end
            end
            // Close the gap one entry per cycle.
            S_SHIFT: begin
               if (pos_inc < count_ff) begin
                  id_mem[pos_ff]    <= id_mem[pos_inc[IW-1:0]];
                  st_mem[pos_ff]    <= st_mem[pos_inc[IW-1:0]];
                  pri_mem[pos_ff]   <= pri_mem[pos_inc[IW-1:0]];
                  slice_mem[pos_ff] <= slice_mem[pos_inc[IW-1:0]];
                  used_mem[pos_ff]  <= used_mem[pos_inc[IW-1:0]];
                  pos_ff <= pos_inc[IW-1:0];
               end else begin
                  count_ff <= count_ff - CW'(1);
                  if (run_ext >= count_ff - CW'(1)) run_ff <= '0;
                  else if (run_ext > scan_ff) run_ff <= run_ff - IW'(1);
                  fsm_ff <= S_READ_ID;
               end
            end
            // Candidate id probe: scan the table for a clash, bump on hit.
            S_ALLOC: begin
               if (scan_ff >= count_ff) begin
                  id_mem[count_ff[IW-1:0]]    <= cand_ff;
                  st_mem[count_ff[IW-1:0]]    <= TASK_READY;
                  pri_mem[count_ff[IW-1:0]]   <= pri_ff;
                  slice_mem[count_ff[IW-1:0]] <= slice_length;
                  used_mem[count_ff[IW-1:0]]  <= '0;
                  count_ff  <= count_ff + CW'(1);
                  free_ff   <= cand_inc;
                  new_id_ff <= cand_ff;
                  fsm_ff    <= S_READ_ID;
               end else if (id_mem[scan_ff[IW-1:0]] == cand_ff) begin
                  cand_ff <= cand_inc;
                  scan_ff <= '0;
               end else begin
                  scan_ff <= scan_ff + CW'(1);
               end
            end
            S_TICK: begin
               if (count_ff <= CW'(1) || run_ext >= count_ff) begin
                  fsm_ff <= S_READ_ID;
               end else begin
                  if (slice_mem[run_ff] != '0) begin
                     slice_mem[run_ff] <= slice_mem[run_ff] - SliceWidth'(1);
                     used_mem[run_ff]  <= used_mem[run_ff] + UsedWidth'(1);
                  end
                  if (slice_mem[run_ff] > SliceWidth'(1) && st_mem[run_ff] == TASK_RUNNING) begin
                     fsm_ff <= S_READ_ID;
                  end else begin
                     pos_ff  <= run_next;
                     scan_ff <= '0;
                     fsm_ff  <= S_PICK;
                  end
               end
            end
            // Wrapping priority scan: one compare per cycle.
            S_PICK: begin
               if (scan_ff >= count_ff) begin
                  fsm_ff <= S_PICK_DONE;
               end else begin
                  if (st_mem[pos_ff] == TASK_READY &&
                      (!found_ff || pri_mem[pos_ff] < best_pri_ff)) begin
                     found_ff    <= 1'b1;
                     best_ff     <= pos_ff;
                     best_pri_ff <= pri_mem[pos_ff];
                  end
                  pos_ff  <= pos_next;
                  scan_ff <= scan_ff + CW'(1);
               end
            end
            S_PICK_DONE: begin
               slice_mem[run_ff] <= slice_length;
               if (found_ff ? (best_ff != run_ff)
                            : (st_mem[run_ff] != TASK_RUNNING && run_ff != '0)) begin
                  if (st_mem[run_ff] == TASK_RUNNING) st_mem[run_ff] <= TASK_READY;
                  if (found_ff) begin
                     slice_mem[best_ff] <= slice_length;
                     st_mem[best_ff]    <= TASK_RUNNING;
                     run_ff             <= best_ff;
                  end else begin
                     slice_mem[0] <= slice_length;
                     st_mem[0]    <= TASK_RUNNING;
                     run_ff       <= '0;
                  end
                  sw_ff <= 1'b1;
               end
               fsm_ff <= S_READ_ID;
            end
            S_READ_ID: begin
               cur_id_ff <= id_mem[run_ff];
               fsm_ff    <= S_DONE;
            end
            S_DONE: begin
               fsm_ff <= S_IDLE;
            end
            default: fsm_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

/* rtl/ptss_checker.sv */
`default_nettype none
module ptss_checker
   import ptss_pkg::*;
#(
   parameter int CW = 5
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [CW-1:0] rsp_task_count,
   input wire logic [1:0] rsp_status,
   input wire logic [15:0] rsp_new_id
);

   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(req_valid && !req_stall))
      else $error("request accepted while response pending");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("response dropped");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_task_count != '0) else $error("task count zero");

   a_new_id_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_id != 16'd0 |-> rsp_status == STATUS_OK)
      else $error("new id with error status");

endmodule

bind priority_time_slice_scheduler ptss_checker #(.CW(CW)) u_ptss_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_task_count, .rsp_status, .rsp_new_id
);
`default_nettype wire

/* dv/tb_priority_time_slice_scheduler.sv */
`timescale 1ns / 1ps

module tb_priority_time_slice_scheduler;
   import ptss_pkg::*;

   localparam int MaxTasks = 16;
   localparam int CycleLimit = 5000000;
   localparam int ItemsPerPhase = 375;
   localparam int DrainCycles = 40;
   localparam int ReportLimit = 10;
   // Operation codes that the block must reject without side effects.
   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   typedef struct {
      logic [1:0]  status;
      logic [15:0] new_id;
      logic        switched;
      logic [3:0]  previous_index;
      logic [3:0]  current_index;
      logic [15:0] current_id;
      logic [4:0]  task_count;
   } sched_result_type;

   // The scoreboard keeps its own copy of the task table and works out the
   // response of every accepted request transaction, then compares the
   // responses in order as they come back.
   class sched_scoreboard;
      logic [15:0]    ids [MaxTasks];
      task_state_type states [MaxTasks];
      logic [7:0]     prios [MaxTasks];
      logic [7:0]     slices [MaxTasks];
      logic [31:0]    used [MaxTasks];
      int             count;
      int             run;
      logic [15:0]    next_id;
      logic [7:0]     slice_len;
      sched_result_type pending [$];
      int             mismatches;

      function new();
         for (int i = 0; i < MaxTasks; i++) begin
            ids[i] = '0;
            states[i] = TASK_READY;
            prios[i] = '0;
            slices[i] = '0;
            used[i] = '0;
         end
         slice_len = 8'd3;
         states[0] = TASK_RUNNING;
         slices[0] = slice_len;
         count = 1;
         run = 0;
         next_id = 16'd1;
         mismatches = 0;
      endfunction

      function int find_task(logic [15:0] id);
         for (int i = 0; i < count; i++) begin
            if (ids[i] == id) return i;
         end
         return -1;
      endfunction

      function int pick_next(int cur);
         int k;
         int best;
         bit found;
         best = 0;
         found = 0;
         for (int i = 0; i < count; i++) begin
            k = (cur + 1 + i) % count;
            if (states[k] == TASK_READY && (!found || prios[k] < prios[best])) begin
               found = 1;
               best = k;
            end
         end
         if (found) return best;
         if (states[cur] == TASK_RUNNING) return cur;
         return 0;
      endfunction

      function bit advance_tick();
         int cur;
         int nxt;
         if (count <= 1 || run >= count) return 0;
         cur = run;
         if (slices[cur] > 0) begin
            slices[cur]--;
            used[cur]++;
         end
         if (slices[cur] > 0 && states[cur] == TASK_RUNNING) return 0;
         nxt = pick_next(cur);
         slices[cur] = slice_len;
         if (nxt == cur) return 0;
         if (states[cur] == TASK_RUNNING) states[cur] = TASK_READY;
         slices[nxt] = slice_len;
         states[nxt] = TASK_RUNNING;
         run = nxt;
         return 1;
      endfunction

      function void note_request(logic [2:0] op, logic [15:0] id, logic [7:0] prio);
         sched_result_type r;
         int k;
         logic [15:0] cand;
         r.status = STATUS_OK;
         r.new_id = '0;
         r.switched = 0;
         r.previous_index = run[3:0];
         case (op)
            OP_TICK: begin
               r.switched = advance_tick();
            end
            OP_YIELD: begin
               if (run < count) begin
                  if (states[run] == TASK_RUNNING) states[run] = TASK_READY;
                  slices[run] = '0;
               end
               r.switched = advance_tick();
            end
            OP_CREATE: begin
               if (count >= MaxTasks) begin
                  r.status = STATUS_FULL;
               end else begin
                  cand = next_id;
                  while (find_task(cand) >= 0) begin
                     cand = cand + 16'd1;
                     if (cand == 0) cand = 16'd1;
                  end
                  ids[count] = cand;
                  next_id = cand + 16'd1;
                  if (next_id == 0) next_id = 16'd1;
                  states[count] = TASK_READY;
                  prios[count] = prio;
                  slices[count] = slice_len;
                  used[count] = '0;
                  count++;
                  r.new_id = cand;
               end
            end
            OP_TERMINATE: begin
               k = find_task(id);
               if (id == 0) begin
                  r.status = STATUS_KERNEL;
               end else if (k < 0) begin
                  r.status = STATUS_NOEFFECT;
               end else begin
                  for (int j = k; j + 1 < count; j++) begin
                     ids[j] = ids[j + 1];
                     states[j] = states[j + 1];
                     prios[j] = prios[j + 1];
                     slices[j] = slices[j + 1];
                     used[j] = used[j + 1];
                  end
                  count--;
                  if (run >= count) run = 0;
                  else if (run > k) run--;
               end
            end
            OP_BLOCK, OP_UNBLOCK: begin
               k = find_task(id);
               if (op == OP_BLOCK && k >= 0 && states[k] == TASK_RUNNING)
                  states[k] = TASK_BLOCKED;
               else if (op == OP_UNBLOCK && k >= 0 && states[k] == TASK_BLOCKED)
                  states[k] = TASK_READY;
               else
                  r.status = STATUS_NOEFFECT;
            end
            default: begin
               r.status = STATUS_NOEFFECT;
            end
         endcase
         r.current_index = run[3:0];
         r.current_id = ids[run];
         r.task_count = count[4:0];
         pending.push_back(r);
      endfunction

      function void check_response(sched_result_type got);
         sched_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit)
               $display("%0t: response transaction with nothing expected", $realtime);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status || got.new_id !== want.new_id ||
             got.switched !== want.switched || got.previous_index !== want.previous_index ||
             got.current_index !== want.current_index || got.current_id !== want.current_id ||
             got.task_count !== want.task_count) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
               $display("%0t: mismatch, expected st=%0d new=%0d sw=%0d prev=%0d cur=%0d id=%0d n=%0d",
                        $realtime, want.status, want.new_id, want.switched,
                        want.previous_index, want.current_index, want.current_id,
                        want.task_count);
               $display("%0t:           actual st=%0d new=%0d sw=%0d prev=%0d cur=%0d id=%0d n=%0d",
                        $realtime, got.status, got.new_id, got.switched,
                        got.previous_index, got.current_index, got.current_id,
                        got.task_count);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_slice_length;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_operation;
   logic [15:0] req_task_id;
   logic [7:0]  req_task_priority;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_new_id;
   logic        rsp_switched;
   logic [3:0]  rsp_previous_index;
   logic [3:0]  rsp_current_index;
   logic [15:0] rsp_current_id;
   logic [4:0]  rsp_task_count;

   sched_scoreboard sched_sb;
   int idle_pct;
   int stall_pct;
   int cycle_count;

   priority_time_slice_scheduler #(.MAX_TASKS(MaxTasks)) dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_slice_length(csr_slice_length),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_task_id(req_task_id),
      .req_task_priority(req_task_priority),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_new_id(rsp_new_id),
      .rsp_switched(rsp_switched),
      .rsp_previous_index(rsp_previous_index),
      .rsp_current_index(rsp_current_index),
      .rsp_current_id(rsp_current_id),
      .rsp_task_count(rsp_task_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // The watchdog ends a run that hangs; it counts every clock from the start.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // The response side samples the handshake at each rising edge, before any
   // update of that edge lands, and picks a fresh random stall for the next cycle.
   always @(posedge clock) begin
      sched_result_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.status = rsp_status;
            got.new_id = rsp_new_id;
            got.switched = rsp_switched;
            got.previous_index = rsp_previous_index;
            got.current_index = rsp_current_index;
            got.current_id = rsp_current_id;
            got.task_count = rsp_task_count;
            sched_sb.check_response(got);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Sends one request transaction. The task is entered just after a rising
   // edge and returns at the edge that accepted the transaction, so valid is
   // only ever assigned once per time step.
   task automatic send_request(logic [2:0] op, logic [15:0] id, logic [7:0] prio);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_task_id <= id;
      req_task_priority <= prio;
      do @(posedge clock); while (req_stall);
      sched_sb.note_request(op, id, prio);
   endtask

   // Lowers valid and waits until every expected response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sched_sb.pending.size() != 0) @(posedge clock);
   endtask

   // The slice length is only written while the block is idle, so the
   // scoreboard copy can be updated at the same edge without ambiguity.
   task automatic write_slice_length(logic [7:0] value);
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      csr_valid <= 1'b1;
      csr_slice_length <= value;
      do @(posedge clock); while (!csr_ready);
      sched_sb.slice_len = value;
      csr_valid <= 1'b0;
   endtask

   // Picks an id that is likely in the table, sometimes a random one.
   function automatic logic [15:0] pick_task_id();
      if ($urandom_range(9) == 0) return 16'($urandom);
      return sched_sb.ids[$urandom_range(sched_sb.count - 1)];
   endfunction

   // Random operations are weighted toward legal sequences: creates keep the
   // table populated, block mostly targets the running task and unblock a
   // known task, so the scheduler reaches its deeper states.
   task automatic send_random_request();
      int r;
      r = $urandom_range(99);
      if (r < 33)
         send_request(OP_TICK, 16'($urandom), 8'($urandom));
      else if (r < 43)
         send_request(OP_YIELD, 16'($urandom), 8'($urandom));
      else if (r < 63)
         send_request(OP_CREATE, 16'($urandom), 8'($urandom));
      else if (r < 73)
         send_request(OP_TERMINATE, pick_task_id(), 8'($urandom));
      else if (r < 84)
         send_request(OP_BLOCK, ($urandom_range(2) != 0) ? sched_sb.ids[sched_sb.run]
                                                         : pick_task_id(), 8'($urandom));
      else if (r < 97)
         send_request(OP_UNBLOCK, pick_task_id(), 8'($urandom));
      else
         send_request(($urandom_range(1) != 0) ? OP_UNUSED_HI : OP_UNUSED_LO,
                      16'($urandom), 8'($urandom));
   endtask

   initial begin
      logic [7:0] slice_settings [4];
      int phase_idle [4];
      int phase_stall [4];

      sched_sb = new();
      cycle_count = 0;
      idle_pct = 0;
      stall_pct = 0;
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_slice_length <= '0;
      req_valid <= 1'b0;
      req_operation <= OP_TICK;
      req_task_id <= '0;
      req_task_priority <= '0;
      rsp_stall <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the reset slice length: single-task tick and
      // yield, priority extremes, block and unblock in right and wrong
      // states, the kernel task refusal, unknown ids and unused codes.
      send_request(OP_TICK, 16'h0000, 8'h00);
      send_request(OP_YIELD, 16'hFFFF, 8'hFF);
      send_request(OP_TICK, 16'h0000, 8'h00);
      send_request(OP_CREATE, 16'h0000, 8'hFF);
      send_request(OP_CREATE, 16'hFFFF, 8'h00);
      send_request(OP_CREATE, 16'h0000, 8'h00);
      send_request(OP_TICK, 16'h0000, 8'h00);
      send_request(OP_TICK, 16'h0000, 8'h00);
      send_request(OP_TICK, 16'h0000, 8'h00);
      send_request(OP_YIELD, 16'h0000, 8'h00);
      send_request(OP_BLOCK, sched_sb.ids[sched_sb.run], 8'h00);
      send_request(OP_TICK, 16'h0000, 8'h00);
      send_request(OP_BLOCK, 16'hFFFF, 8'hFF);
      send_request(OP_UNBLOCK, 16'd3, 8'h00);
      send_request(OP_UNBLOCK, 16'd2, 8'h00);
      send_request(OP_UNBLOCK, 16'd1, 8'h00);
      send_request(OP_TERMINATE, 16'h0000, 8'h00);
      send_request(OP_TERMINATE, 16'hFFFF, 8'h00);
      send_request(OP_TERMINATE, 16'd2, 8'h00);
      send_request(OP_UNUSED_LO, 16'h1234, 8'h5A);
      send_request(OP_UNUSED_HI, 16'hEDCB, 8'hA5);
      send_request(OP_YIELD, 16'h0000, 8'h00);

      // Each phase writes a new slice length, including zero and the top
      // value, and runs under its own idling pattern.
      slice_settings = '{8'd1, 8'd0, 8'd255, 8'($urandom_range(2, 254))};
      phase_idle = '{0, 74, 0, 18};
      phase_stall = '{0, 0, 74, 18};
      for (int p = 0; p < 4; p++) begin
         write_slice_length(slice_settings[p]);
         idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         @(posedge clock);
         for (int i = 0; i < ItemsPerPhase; i++) begin
            send_random_request();
            // One hold-off in the middle of a phase lets the block run dry.
            if (p == 1 && i == ItemsPerPhase / 2) wait_drained();
         end
      end

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (sched_sb.mismatches == 0 && sched_sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
